@@ rtl/core/dhar_pkg.sv @@
// Shared constants and types for the decimating history with auto-ranging bounds.
package dhar_pkg;

    localparam int DEPTH       = 256;
    localparam int ADDR_W      = $clog2(DEPTH + 1);
    localparam int CNT_W       = $clog2(DEPTH + 2);
    localparam int CFG_W       = 9;
    localparam int IDX_W       = 8;
    localparam int RAW_W       = 16;
    localparam int FRAC_W      = 8;
    localparam int EASE_W      = RAW_W + FRAC_W;
    localparam int DIFF_W      = EASE_W + 1;
    localparam int ALPHA_W     = 14;
    localparam int PROD_W      = DIFF_W + ALPHA_W;
    localparam int ALPHA_SHIFT = 16;
    localparam int LIM_W       = CFG_W + CNT_W;
    localparam int CMP_W       = IDX_W + CNT_W;
    localparam int MIN_LIMIT   = 2;

    localparam logic signed [ALPHA_W-1:0] ALPHA_NUM = 14'sd6554;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_RD_WAIT  = 7'b0000010,
        ST_COMP     = 7'b0000100,
        ST_EASE_LO  = 7'b0001000,
        ST_EASE_HI  = 7'b0010000,
        ST_EASE_ADD = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

endpackage

@@ rtl/core/dhar_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
module dhar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/decimating_history_auto_range.sv @@
// Top level: sample history with two-to-one decimation and eased min/max bounds.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+--------------------------------------
//  config    | in        | max_samples_we       | max_samples_wdata
//  s_ (item) | in        | s_valid / s_ready    | s_op, s_sample, s_index
//  m_ (item) | out       | m_valid / m_ready    | entry, count, compressed, raw/smoothed
//
//  One item at a time. A read waits in ST_RD_WAIT for the RAM data, then loads the result.
//  A push passes ST_EASE_LO/HI/ADD and ST_FINISH (the first push skips HI/ADD);
//  a push that decimates first walks the whole history in ST_COMP, one RAM read
//  per cycle through the single read port. The eased bounds share one multiplier.
//  Reset clears control state and the count; the history RAM is not cleared.
//  The output register lets a new item be accepted while a result waits.
module decimating_history_auto_range (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               max_samples_we,
    input  logic [8:0]         max_samples_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [15:0] s_sample,
    input  logic [7:0]         s_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_entry_value,
    output logic [8:0]         m_sample_count,
    output logic               m_compressed,
    output logic signed [15:0] m_raw_min,
    output logic signed [15:0] m_raw_max,
    output logic signed [23:0] m_smoothed_min,
    output logic signed [23:0] m_smoothed_max
);

    import dhar_pkg::*;

    state_t                     state_reg, state_next;
    logic [CFG_W-1:0]           max_samples_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           ra_reg, ra_next;
    logic                       p_vld_reg, p_vld_next;
    logic [CNT_W-1:0]           p_tag_reg, p_tag_next;
    logic signed [RAW_W-1:0]    a_reg, a_next;
    logic signed [RAW_W-1:0]    lo_reg, lo_next;
    logic signed [RAW_W-1:0]    hi_reg, hi_next;
    logic signed [EASE_W-1:0]   eased_low_reg, eased_low_next;
    logic signed [EASE_W-1:0]   eased_high_reg, eased_high_next;
    logic                       range_valid_reg, range_valid_next;
    logic                       comp_reg, comp_next;
    logic                       hit_reg, hit_next;
    logic signed [RAW_W-1:0]    entry_reg, entry_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;

    logic                       out_valid_reg;
    logic signed [RAW_W-1:0]    out_entry_reg;
    logic [CNT_W-1:0]           out_count_reg;
    logic                       out_comp_reg;
    logic signed [RAW_W-1:0]    out_lo_reg, out_hi_reg;
    logic signed [EASE_W-1:0]   out_slo_reg, out_shi_reg;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr, ram_raddr;
    logic signed [RAW_W-1:0]    ram_wdata, ram_rdata;

    logic [LIM_W-1:0]           lim;
    logic                       accept, load_out;
    logic signed [RAW_W:0]      pair_sum;
    logic signed [RAW_W-1:0]    pair_avg;
    logic signed [RAW_W-1:0]    upd_val;
    logic                       upd;
    logic signed [RAW_W-1:0]    mul_r;
    logic signed [EASE_W-1:0]   mul_s;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   step_q;

    dhar_ram #(
        .WIDTH (RAW_W),
        .DEPTH (DEPTH + 1)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || m_ready);

    // Effective limit: clamp the register to [2, DEPTH]
    always_comb begin
        lim = LIM_W'(max_samples_reg);
        if (lim < LIM_W'(MIN_LIMIT)) begin
            lim = LIM_W'(MIN_LIMIT);
        end else if (lim > LIM_W'(DEPTH)) begin
            lim = LIM_W'(DEPTH);
        end
    end

    assign pair_sum = {a_reg[RAW_W-1], a_reg} + {ram_rdata[RAW_W-1], ram_rdata};
    assign pair_avg = pair_sum[RAW_W:1];

    assign mul_r  = (state_reg == ST_EASE_LO) ? lo_reg : hi_reg;
    assign mul_s  = (state_reg == ST_EASE_LO) ? eased_low_reg : eased_high_reg;
    assign diff   = {mul_r[RAW_W-1], mul_r, {FRAC_W{1'b0}}} - {mul_s[EASE_W-1], mul_s};
    assign step_q = prod_reg >>> ALPHA_SHIFT;

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        n_next           = n_reg;
        ra_next          = ra_reg;
        p_vld_next       = 1'b0;
        p_tag_next       = p_tag_reg;
        a_next           = a_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        eased_low_next   = eased_low_reg;
        eased_high_next  = eased_high_reg;
        range_valid_next = range_valid_reg;
        comp_next        = comp_reg;
        hit_next         = hit_reg;
        entry_next       = entry_reg;
        prod_next        = prod_reg;
        ram_we           = 1'b0;
        ram_waddr        = ADDR_W'(count_reg);
        ram_wdata        = s_sample;
        ram_raddr        = ADDR_W'(s_index);
        upd              = 1'b0;
        upd_val          = ram_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    comp_next = 1'b0;
                    if (s_op == OP_READ) begin
                        hit_next   = CMP_W'(s_index) < CMP_W'(count_reg);
                        state_next = ST_RD_WAIT;
                    end else begin
                        ram_we  = 1'b1;
                        n_next  = count_reg + 1'b1;
                        ra_next = '0;
                        if (LIM_W'(count_reg) + 1'b1 > lim) begin
                            state_next = ST_COMP;
                        end else begin
                            count_next = count_reg + 1'b1;
                            if (count_reg == '0) begin
                                lo_next = s_sample;
                                hi_next = s_sample;
                            end else begin
                                if (s_sample < lo_reg) lo_next = s_sample;
                                if (s_sample > hi_reg) hi_next = s_sample;
                            end
                            state_next = ST_EASE_LO;
                        end
                    end
                end
            end
            ST_RD_WAIT: begin
                entry_next = hit_reg ? ram_rdata : '0;
                state_next = ST_FINISH;
            end
            ST_COMP: begin
                // Issue one read a cycle; fold pairs as the data returns
                ram_raddr = ADDR_W'(ra_reg);
                if (ra_reg < n_reg) begin
                    p_vld_next = 1'b1;
                    p_tag_next = ra_reg;
                    ra_next    = ra_reg + 1'b1;
                end
                ram_waddr = ADDR_W'(p_tag_reg >> 1);
                if (p_vld_reg) begin
                    if (!p_tag_reg[0]) begin
                        a_next = ram_rdata;
                        // Odd leftover: carry the last sample over unaveraged
                        if (p_tag_reg == n_reg - 1'b1) begin
                            upd     = 1'b1;
                            upd_val = ram_rdata;
                        end
                    end else begin
                        upd     = 1'b1;
                        upd_val = pair_avg;
                    end
                    if (upd) begin
                        ram_we    = 1'b1;
                        ram_wdata = upd_val;
                        if ((p_tag_reg >> 1) == '0) begin
                            lo_next = upd_val;
                            hi_next = upd_val;
                        end else begin
                            if (upd_val < lo_reg) lo_next = upd_val;
                            if (upd_val > hi_reg) hi_next = upd_val;
                        end
                    end
                    if (p_tag_reg == n_reg - 1'b1) begin
                        count_next = (n_reg >> 1) + CNT_W'(n_reg[0]);
                        comp_next  = 1'b1;
                        state_next = ST_EASE_LO;
                    end
                end
            end
            ST_EASE_LO: begin
                if (!range_valid_reg) begin
                    eased_low_next   = {lo_reg, {FRAC_W{1'b0}}};
                    eased_high_next  = {hi_reg, {FRAC_W{1'b0}}};
                    range_valid_next = 1'b1;
                    state_next       = ST_FINISH;
                end else begin
                    prod_next  = diff * ALPHA_NUM;
                    state_next = ST_EASE_HI;
                end
            end
            ST_EASE_HI: begin
                eased_low_next = eased_low_reg + step_q[EASE_W-1:0];
                prod_next      = diff * ALPHA_NUM;
                state_next     = ST_EASE_ADD;
            end
            ST_EASE_ADD: begin
                eased_high_next = eased_high_reg + step_q[EASE_W-1:0];
                state_next      = ST_FINISH;
            end
            ST_FINISH: begin
                if (load_out) begin
                    entry_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            max_samples_reg <= CFG_W'(256);
            count_reg       <= '0;
            p_vld_reg       <= 1'b0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            eased_low_reg   <= '0;
            eased_high_reg  <= '0;
            range_valid_reg <= 1'b0;
            entry_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            p_vld_reg       <= p_vld_next;
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            eased_low_reg   <= eased_low_next;
            eased_high_reg  <= eased_high_next;
            range_valid_reg <= range_valid_next;
            entry_reg       <= entry_next;
            if (max_samples_we) begin
                max_samples_reg <= max_samples_wdata;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        ra_reg    <= ra_next;
        p_tag_reg <= p_tag_next;
        a_reg     <= a_next;
        comp_reg  <= comp_next;
        hit_reg   <= hit_next;
        prod_reg  <= prod_next;
        if (load_out) begin
            out_entry_reg <= entry_reg;
            out_count_reg <= count_reg;
            out_comp_reg  <= comp_reg;
            out_lo_reg    <= lo_reg;
            out_hi_reg    <= hi_reg;
            out_slo_reg   <= eased_low_reg;
            out_shi_reg   <= eased_high_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_entry_value  = out_entry_reg;
    assign m_sample_count = 9'(out_count_reg);
    assign m_compressed   = out_comp_reg;
    assign m_raw_min      = out_lo_reg;
    assign m_raw_max      = out_hi_reg;
    assign m_smoothed_min = out_slo_reg;
    assign m_smoothed_max = out_shi_reg;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for the decimating sample history with eased min/max bounds.
`timescale 1ns / 100ps

module tb_top;

    import dhar_pkg::DEPTH;
    import dhar_pkg::MIN_LIMIT;
    import dhar_pkg::ALPHA_NUM;
    import dhar_pkg::ALPHA_SHIFT;
    import dhar_pkg::OP_PUSH;
    import dhar_pkg::OP_READ;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic               op;
        logic signed [15:0] sample;
        logic [7:0]         index;
        bit                 aim_live;   // pick a live index when the item goes out
    } trace_item_t;

    typedef struct {
        logic signed [15:0] entry;
        logic [8:0]         count;
        logic               compressed;
        logic signed [15:0] raw_lo;
        logic signed [15:0] raw_hi;
        logic signed [23:0] eased_lo;
        logic signed [23:0] eased_hi;
    } trace_view_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               max_samples_we = 1'b0;
    logic [8:0]         max_samples_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op = 1'b0;
    logic signed [15:0] s_sample = '0;
    logic [7:0]         s_index = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_entry_value;
    logic [8:0]         m_sample_count;
    logic               m_compressed;
    logic signed [15:0] m_raw_min;
    logic signed [15:0] m_raw_max;
    logic signed [23:0] m_smoothed_min;
    logic signed [23:0] m_smoothed_max;

    decimating_history_auto_range DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .max_samples_we    (max_samples_we),
        .max_samples_wdata (max_samples_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_sample          (s_sample),
        .s_index           (s_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_entry_value     (m_entry_value),
        .m_sample_count    (m_sample_count),
        .m_compressed      (m_compressed),
        .m_raw_min         (m_raw_min),
        .m_raw_max         (m_raw_max),
        .m_smoothed_min    (m_smoothed_min),
        .m_smoothed_max    (m_smoothed_max)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Shadow copy of the history and the eased bounds
    logic signed [15:0] hist [0:DEPTH];
    int unsigned        held = 0;
    logic signed [23:0] bound_lo = '0;
    logic signed [23:0] bound_hi = '0;
    bit                 bounds_loaded = 0;
    int unsigned        limit_reg = 256;

    trace_item_t items_to_send [$];
    trace_view_t views_due [$];
    int          mismatches = 0;
    int unsigned results_seen = 0;

    function automatic logic signed [23:0] ease_toward(logic signed [23:0] s,
                                                       logic signed [15:0] r);
        longint p;
        p = (longint'(r) * 256 - longint'(s)) * longint'(ALPHA_NUM);
        // arithmetic shift floors toward minus infinity
        return 24'(longint'(s) + (p >>> ALPHA_SHIFT));
    endfunction

    function automatic trace_view_t predict_view(trace_item_t it);
        trace_view_t v;
        int unsigned lim;
        int unsigned half;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        v.entry = '0;
        v.compressed = 1'b0;
        if (it.op == OP_PUSH) begin
            lim = limit_reg;
            if (lim < MIN_LIMIT) lim = MIN_LIMIT;
            if (lim > DEPTH) lim = DEPTH;
            hist[held] = it.sample;
            held++;
            if (held > lim) begin
                half = held / 2;
                for (int i = 0; i < half; i++)
                    hist[i] = 16'((int'(hist[2*i]) + int'(hist[2*i+1])) >>> 1);
                // odd leftover is carried over as it is
                if (held % 2 != 0) begin
                    hist[half] = hist[held-1];
                    held = half + 1;
                end else begin
                    held = half;
                end
                v.compressed = 1'b1;
            end
        end else if (it.index < held) begin
            v.entry = hist[it.index];
        end
        lo = '0;
        hi = '0;
        if (held != 0) begin
            lo = hist[0];
            hi = hist[0];
            for (int i = 1; i < held; i++) begin
                if (hist[i] < lo) lo = hist[i];
                if (hist[i] > hi) hi = hist[i];
            end
        end
        if (it.op == OP_PUSH) begin
            if (!bounds_loaded) begin
                bound_lo = {lo, 8'd0};
                bound_hi = {hi, 8'd0};
                bounds_loaded = 1;
            end else begin
                bound_lo = ease_toward(bound_lo, lo);
                bound_hi = ease_toward(bound_hi, hi);
            end
        end
        v.count = 9'(held);
        v.raw_lo = lo;
        v.raw_hi = hi;
        v.eased_lo = bound_lo;
        v.eased_hi = bound_hi;
        return v;
    endfunction

    // Driver: offer queued items with a random wait drawn per item
    trace_item_t cur_item;
    int unsigned tx_gap = 0;
    bit          tx_steady = 0;

    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                views_due.push_back(predict_view(cur_item));
                offer = 1'b0;
            end
            if (!offer) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (items_to_send.size() != 0) begin
                    cur_item = items_to_send.pop_front();
                    if (cur_item.op == OP_READ && cur_item.aim_live && held != 0)
                        cur_item.index = 8'($urandom_range(0, held - 1));
                    s_op     <= cur_item.op;
                    s_sample <= cur_item.sample;
                    s_index  <= cur_item.index;
                    offer = 1'b1;
                    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
                    tx_gap = tx_steady ? 0 : $urandom_range(0, 15);
                end
            end
            s_valid <= offer;
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    int unsigned hold_left = 0;
    bit          hold_done = 0;

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1;
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: take results and compare against the oldest prediction
    int unsigned rx_gap = 0;
    bit          rx_steady = 0;

    always @(posedge aclk) begin
        trace_view_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (views_due.size() == 0) begin
                    $error("result item with no prediction waiting");
                    mismatches++;
                end else begin
                    want = views_due.pop_front();
                    check_field("entry_value", want.entry, m_entry_value);
                    check_field("sample_count", want.count, m_sample_count);
                    check_field("compressed", want.compressed, m_compressed);
                    check_field("raw_min", want.raw_lo, m_raw_min);
                    check_field("raw_max", want.raw_hi, m_raw_max);
                    check_field("smoothed_min", want.eased_lo, m_smoothed_min);
                    check_field("smoothed_max", want.eased_hi, m_smoothed_max);
                end
                if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
                rx_gap = rx_steady ? 0 : $urandom_range(0, 15);
            end else if (rx_gap != 0) begin
                rx_gap--;
            end
            m_ready <= (rx_gap == 0) && (hold_left == 0);
        end
    end

    int unsigned quiet = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic add_item(input logic op, input logic signed [15:0] smp,
                            input logic [7:0] idx);
        trace_item_t it;
        it.op = op;
        it.sample = smp;
        it.index = idx;
        it.aim_live = 0;
        items_to_send.push_back(it);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return 16'($urandom_range(0, 63) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_random(input int n, input int push_pct);
        trace_item_t it;
        for (int k = 0; k < n; k++) begin
            it.op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_READ;
            it.sample = pick_sample();
            it.index = 8'($urandom_range(0, 255));
            it.aim_live = ($urandom_range(0, 3) != 0);
            items_to_send.push_back(it);
        end
    endtask

    // Wait until the block is idle with nothing outstanding; sample between edges
    task automatic settle();
        while (items_to_send.size() != 0 || s_valid || views_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [8:0] value);
        @(posedge aclk);
        max_samples_we    <= 1'b1;
        max_samples_wdata <= value;
        @(posedge aclk);
        max_samples_we    <= 1'b0;
        limit_reg = value;
    endtask

    initial begin
        logic [8:0] phase_limits [7];
        phase_limits = '{9'd511, 9'd1, 9'd257, 9'd3, 9'd256, 9'd2,
                         9'($urandom_range(4, 200))};

        // empty history, extremes, reads inside and past the count
        add_item(OP_READ, 16'sh0000, 8'd0);
        add_item(OP_READ, 16'sh0000, 8'd255);
        add_item(OP_PUSH, 16'sh7FFF, 8'd0);
        add_item(OP_PUSH, 16'sh8000, 8'd255);
        add_item(OP_PUSH, 16'sh0000, 8'd0);
        add_item(OP_PUSH, 16'shFFFF, 8'd0);
        for (int k = 0; k < 5; k++) add_item(OP_READ, 16'sh0000, 8'(k));
        add_item(OP_READ, 16'sh7FFF, 8'd255);
        settle();

        // limit below the clamp and below the current count: odd and even halving
        set_limit(9'd0);
        add_item(OP_PUSH, 16'sh0005, 8'd0);
        add_item(OP_PUSH, -16'sd7, 8'd0);
        add_item(OP_PUSH, 16'sh0064, 8'd0);
        add_item(OP_READ, 16'sh0000, 8'd0);
        add_item(OP_READ, 16'sh0000, 8'd1);
        add_item(OP_READ, 16'sh0000, 8'd2);

        foreach (phase_limits[p]) begin
            settle();
            set_limit(phase_limits[p]);
            // first phase runs long enough to fill the history to the top
            if (p == 0) add_random(300, 90);
            else        add_random(45, 65);
        end

        settle();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && views_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
